// ===== hdl/shts_pkg.sv =====
// ============================================================================
// shts_pkg - shared types and constants for the sorted hash table search
// Field widths, kind codes and the structs passed between the search engine,
// the table memory and the top level.
// ============================================================================
package shts_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int KEY_W    = 64;
    localparam int OFFSET_W = 32;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // One input word after unpacking.
    typedef struct packed {
        logic                kind;
        logic [INDEX_W-1:0]  entry_index;
        logic [KEY_W-1:0]    key_hash;
        logic [OFFSET_W-1:0] name_offset;
    } shts_item_t;

    // One result word.
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
        logic [INDEX_W-1:0]  match_index;
    } shts_res_t;

    // Table write request; the address travels beside it.
    typedef struct packed {
        logic                en;
        logic [KEY_W-1:0]    key;
        logic [OFFSET_W-1:0] offset;
    } shts_wr_t;

    // Registered table read data.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [OFFSET_W-1:0] offset;
    } shts_rd_t;

endpackage

// ===== hdl/shts_table.sv =====
// ============================================================================
// shts_table - key and offset table memory
// Synchronous memory with one write port and one read port; read data is
// registered and holds while no read is issued.
// ============================================================================
module shts_table
    import shts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic              aclk,
    input  shts_wr_t          wr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output shts_rd_t          rd
);

    logic [KEY_W-1:0]    key_mem [TABLE_DEPTH];
    logic [OFFSET_W-1:0] off_mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            key_mem[wr_addr] <= wr.key;
            off_mem[wr_addr] <= wr.offset;
        end
        if (rd_en) begin
            rd.key    <= key_mem[rd_addr];
            rd.offset <= off_mem[rd_addr];
        end
    end

endmodule

// ===== hdl/shts_search.sv =====
// ============================================================================
// shts_search - load and binary search sequencer
// Writes load words into the table and runs one probe per cycle for a
// search, issuing the next read while the current one is compared.
// ============================================================================
module shts_search
    import shts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  shts_item_t         item,
    input  logic [COUNT_W-1:0] valid_count,
    output shts_wr_t           wr,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  shts_rd_t           rd,
    output logic               m_valid,
    input  logic               m_ready,
    output shts_res_t          m_res
);

    localparam int SPAN_W = ADDR_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ADDR_W-1:0]   low_reg;
    logic [ADDR_W-1:0]   high_reg;
    logic [ADDR_W-1:0]   mid_reg;
    shts_res_t           res_reg;
    shts_res_t           m_res_reg;
    logic                m_valid_reg;

    logic [SPAN_W-1:0]   span;
    logic [ADDR_W-1:0]   high_first;
    logic [ADDR_W-1:0]   mid_first;
    logic [ADDR_W-1:0]   low_up;
    logic [ADDR_W-1:0]   mid_up;
    logic [ADDR_W-1:0]   high_dn;
    logic [ADDR_W-1:0]   mid_dn;
    logic                hit;
    logic                below;
    logic                go_on;
    logic                accept;
    logic                hand_over;

    // Saturate the count at the table depth.
    always_comb begin
        if (32'(valid_count) > 32'(TABLE_DEPTH)) begin
            span = SPAN_W'(TABLE_DEPTH);
        end else begin
            span = SPAN_W'(valid_count);
        end
    end

    assign high_first = ADDR_W'(span - SPAN_W'(1));
    assign mid_first  = high_first >> 1;

    // Both possible next probes are formed while the key compare settles.
    assign low_up  = mid_reg + ADDR_W'(1);
    assign mid_up  = low_up + ((high_reg - low_up) >> 1);
    assign high_dn = mid_reg - ADDR_W'(1);
    assign mid_dn  = low_reg + ((high_dn - low_reg) >> 1);

    assign hit   = (rd.key == key_reg);
    assign below = (rd.key < key_reg);
    assign go_on = below ? (mid_reg < high_reg) : (mid_reg > low_reg);

    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Hand over once the output register is free or being emptied.
    assign hand_over = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign wr.en     = accept && (item.kind == KIND_LOAD)
                       && (32'(item.entry_index) < 32'(TABLE_DEPTH));
    assign wr.key    = item.key_hash;
    assign wr.offset = item.name_offset;
    assign wr_addr   = ADDR_W'(item.entry_index);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = mid_first;
        unique case (state_reg)
            ST_IDLE: begin
                rd_en   = accept && (item.kind == KIND_SEARCH) && (span != '0);
                rd_addr = mid_first;
            end
            ST_PROBE: begin
                rd_en   = !hit && go_on;
                rd_addr = below ? mid_up : mid_dn;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (hand_over) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (item.kind == KIND_SEARCH)) begin
                        key_reg <= item.key_hash;
                        if (span == '0) begin
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            low_reg   <= '0;
                            high_reg  <= high_first;
                            mid_reg   <= mid_first;
                            state_reg <= ST_PROBE;
                        end
                    end
                end
                ST_PROBE: begin
                    if (hit) begin
                        res_reg.found        <= 1'b1;
                        res_reg.match_offset <= rd.offset;
                        res_reg.match_index  <= INDEX_W'(mid_reg);
                        state_reg            <= ST_DONE;
                    end else if (!go_on) begin
                        res_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else if (below) begin
                        low_reg <= low_up;
                        mid_reg <= mid_up;
                    end else begin
                        high_reg <= high_dn;
                        mid_reg  <= mid_dn;
                    end
                end
                ST_DONE: begin
                    if (hand_over) begin
                        m_res_reg <= res_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

// ===== hdl/sorted_hash_table_search.sv =====
// ============================================================================
// sorted_hash_table_search - binary search over a sorted key table
// Loads 64-bit keys with 32-bit string offsets into a table and answers
// searches with found flag, offset and entry position.
// ============================================================================
//
//  channel   direction  handshake              contents
//  s_*       in         s_tvalid / s_tready    load or search word
//  m_*       out        m_tvalid / m_tready    search result word
//  cfg_*     in         cfg_valid / cfg_ready  valid entry count register
//
//  A load is written as it is accepted and leaves the input ready. A search
//  holds off the next word until its result has left the done state; it
//  makes P probes, P being at most floor(log2 n) + 1, and each probe is one
//  read of the table memory. An empty table gives a miss without a read.
//  Reset is synchronous and clears only control state; the table is
//  undefined until loaded. A result waiting in the output register does not
//  block acceptance of the next word; that word's result then waits in the
//  search engine, and no further word is taken until it has been handed over.
//
module sorted_hash_table_search
    import shts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [111:0]        s_tdata,   // entry_index, key_hash, name_offset, zero pad
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // match_offset, match_index, zero pad
    output logic                m_tuser,   // found
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0] valid_count_reg;
    shts_item_t         item;
    shts_wr_t           wr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    shts_rd_t           rd;
    shts_res_t          res;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            valid_count_reg <= cfg_data;
        end
    end

    assign item.kind        = s_tuser;
    assign item.entry_index = s_tdata[11:0];
    assign item.key_hash    = s_tdata[75:12];
    assign item.name_offset = s_tdata[107:76];

    shts_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .item        (item),
        .valid_count (valid_count_reg),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd          (rd),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_res       (res)
    );

    shts_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    assign m_tuser = res.found;
    assign m_tdata = {4'b0000, res.match_index, res.match_offset};

endmodule

// ===== tb/tb_sorted_hash_table_search.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_sorted_hash_table_search - self-checking bench for the key table search
// Loads sorted and unsorted tables, sets the entry count (empty, one entry,
// small, full and saturated), and runs searches for hits, near misses and
// random keys. Every search result is predicted in the bench and compared
// field by field, with random gaps on the input side and random stalls on
// the result side.
// ============================================================================
module tb_sorted_hash_table_search;
    import shts_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 200;

    localparam logic [KEY_W-1:0] FILL_BASE = 64'h4000_0000_0000_0000;
    localparam logic [KEY_W-1:0] FILL_STEP = 64'h0000_1000_0000_0001;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [111:0]        s_tdata;   // entry_index, key_hash, name_offset, zero pad
    logic                s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic [47:0]         m_tdata;   // match_offset, match_index, zero pad
    logic                m_tuser;   // found
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data;

    // Bench copy of the table and of the entry count register.
    logic [KEY_W-1:0]    tbl_key [DEPTH];
    logic [OFFSET_W-1:0] tbl_off [DEPTH];
    bit                  written [DEPTH];
    logic [COUNT_W-1:0]  valid_count_q;

    shts_res_t           pending_results[$];
    int                  fail_count;
    bit                  no_gaps;

    sorted_hash_table_search #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb_sorted_hash_table_search NOT OK");
        $finish;
    end

    // Binary search over the counted entries, following the same probe
    // order as the hardware, so unsorted tables are predicted too.
    function automatic shts_res_t search_table(input logic [KEY_W-1:0] key);
        shts_res_t res;
        int        n;
        int        lo;
        int        hi;
        int        mid;
        res = '0;
        n   = (valid_count_q > DEPTH) ? DEPTH : int'(valid_count_q);
        if (n == 0) begin
            return res;
        end
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_key[mid] == key) begin
                res.found        = 1'b1;
                res.match_offset = tbl_off[mid];
                res.match_index  = mid[INDEX_W-1:0];
                return res;
            end
            if (tbl_key[mid] < key) begin
                lo = mid + 1;
            end else begin
                if (mid == 0) begin
                    break;
                end
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Ascending key given to an entry of the large table when it is first
    // needed.
    function automatic logic [KEY_W-1:0] fill_key(input int idx);
        return FILL_BASE + FILL_STEP * KEY_W'(idx);
    endfunction

    // Sends one word and updates the prediction when it is taken. Returns at
    // a falling edge with s_tvalid still high, so a back-to-back word keeps it.
    task automatic send_word(input logic kind, input logic [INDEX_W-1:0] idx,
                             input logic [KEY_W-1:0] key,
                             input logic [OFFSET_W-1:0] off);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, off, key, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == KIND_LOAD) begin
            tbl_key[idx] = key;
            tbl_off[idx] = off;
            written[idx] = 1'b1;
        end else begin
            pending_results.insert(pending_results.size(), search_table(key));
        end
        @(negedge aclk);
    endtask

    task automatic send_search(input logic [KEY_W-1:0] key);
        send_word(KIND_SEARCH, INDEX_W'($urandom_range(0, DEPTH - 1)), key, $urandom);
    endtask

    // For the large table only the entries on a search's probe path are
    // loaded, just before the search, so no search meets an unloaded entry.
    task automatic search_full(input logic [KEY_W-1:0] key);
        int n;
        int lo;
        int hi;
        int mid;
        n  = (valid_count_q > DEPTH) ? DEPTH : int'(valid_count_q);
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (!written[mid]) begin
                send_word(KIND_LOAD, INDEX_W'(mid), fill_key(mid), $urandom);
            end
            if (tbl_key[mid] == key) begin
                break;
            end
            if (tbl_key[mid] < key) begin
                lo = mid + 1;
            end else begin
                if (mid == 0) begin
                    break;
                end
                hi = mid - 1;
            end
        end
        send_search(key);
    endtask

    // Stops the input and waits until every expected result has come, then
    // lets the design settle.
    task automatic wait_results_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_valid_count(input logic [COUNT_W-1:0] value);
        wait_results_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        valid_count_q = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Loads entries 0 to n-1 in ascending key order. Small steps now and
    // then give duplicate and adjacent keys.
    task automatic load_sorted(input int n, input logic [KEY_W-1:0] start);
        logic [KEY_W-1:0] key;
        key = start;
        for (int i = 0; i < n; i++) begin
            send_word(KIND_LOAD, INDEX_W'(i), key, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                key = key + KEY_W'($urandom_range(0, 2));
            end else begin
                key = key + (rand_key() >> 13) + 1;
            end
        end
    endtask

    // Mostly searches for stored keys and their neighbours, with some
    // random keys and the odd load anywhere in the table.
    task automatic mix_traffic(input int n_items, input int span);
        int               pick;
        int               idx;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 9);
            idx  = $urandom_range(0, span - 1);
            key  = tbl_key[idx];
            if (pick < 6) begin
                send_search(key);
            end else if (pick == 6) begin
                send_search(key + 1);
            end else if (pick == 7) begin
                send_search(key - 1);
            end else if (pick == 8) begin
                send_search(rand_key());
            end else begin
                send_word(KIND_LOAD, INDEX_W'($urandom_range(0, DEPTH - 1)),
                          rand_key(), $urandom);
            end
        end
    endtask

    // Same mix over the whole depth, with each search's path loaded first.
    task automatic full_traffic(input int n_items);
        int               pick;
        int               idx;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 9);
            idx  = $urandom_range(0, DEPTH - 1);
            key  = written[idx] ? tbl_key[idx] : fill_key(idx);
            if (pick < 6) begin
                search_full(key);
            end else if (pick == 6) begin
                search_full(key + 1);
            end else if (pick == 7) begin
                search_full(key - 1);
            end else if (pick == 8) begin
                search_full(rand_key());
            end else begin
                send_word(KIND_LOAD, INDEX_W'(idx), rand_key(), $urandom);
            end
        end
    endtask

    task automatic test_empty_table();
        send_search(64'h0);
        send_search({KEY_W{1'b1}});
        wait_results_idle();
    endtask

    task automatic test_small_sorted();
        send_word(KIND_LOAD, 12'd0, 64'h0, 32'h0);
        send_word(KIND_LOAD, 12'd1, 64'h0000_0000_dead_beef, 32'hffff_ffff);
        send_word(KIND_LOAD, 12'd2, 64'h0000_0001_0000_0000, 32'h0000_0100);
        send_word(KIND_LOAD, 12'd3, 64'h1234_5678_9abc_def0, 32'h8000_0000);
        send_word(KIND_LOAD, 12'd4, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff);
        send_word(KIND_LOAD, 12'd5, 64'h8000_0000_0000_0000, 32'h5555_aaaa);
        send_word(KIND_LOAD, 12'd6, 64'hffff_ffff_ffff_fff0, 32'h0000_0001);
        send_word(KIND_LOAD, 12'd7, {KEY_W{1'b1}}, 32'hcafe_f00d);
        send_word(KIND_LOAD, 12'd4095, 64'hffff_ffff_0000_0000, 32'hffff_ffff);
        set_valid_count(13'd8);
        send_search(64'h0);
        send_search({KEY_W{1'b1}});
        // A 32-bit key arrives zero-extended.
        send_search(64'h0000_0000_dead_beef);
        send_search(64'h8000_0000_0000_0000);
        send_search(64'h0000_0000_0000_0005);
        send_search(64'hffff_ffff_ffff_fff8);
        wait_results_idle();
    endtask

    task automatic test_single_entry();
        send_word(KIND_LOAD, 12'd0, 64'h40, 32'h1234_5678);
        set_valid_count(13'd1);
        send_search(64'h40);
        send_search(64'h3f);
        send_search(64'h41);
        wait_results_idle();
    endtask

    task automatic test_unsorted_table();
        // A small key placed mid-table is skipped by the probe sequence.
        send_word(KIND_LOAD, 12'd4, 64'h10, 32'h0bad_0bad);
        set_valid_count(13'd8);
        send_search(64'h10);
        send_search(64'h7fff_ffff_ffff_ffff);
        wait_results_idle();
    endtask

    task automatic test_random_tables();
        int sent;
        int n;
        int n_mix;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            n       = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 300)
                                                  : $urandom_range(1, 64);
            no_gaps = ($urandom_range(0, 3) == 0);
            load_sorted(n, rand_key() >> 1);
            if ($urandom_range(0, 4) == 0) begin
                set_valid_count(COUNT_W'($urandom_range(1, n)));
            end else begin
                set_valid_count(COUNT_W'(n));
            end
            n_mix = $urandom_range(10, 40);
            mix_traffic(n_mix, n);
            sent += n + n_mix;
            // Hold the input until the last result has been taken.
            wait_results_idle();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_full_table();
        set_valid_count(COUNT_W'(DEPTH));
        search_full(fill_key(0));
        search_full(fill_key(DEPTH - 1));
        search_full(fill_key(DEPTH / 2));
        full_traffic(10);
        // Counts above the table depth saturate.
        set_valid_count({COUNT_W{1'b1}});
        search_full(fill_key(DEPTH - 1));
        full_traffic(5);
        set_valid_count(COUNT_W'(DEPTH + 1));
        full_traffic(3);
        set_valid_count(COUNT_W'(DEPTH - 1));
        search_full(fill_key(DEPTH - 1));
        search_full(fill_key(DEPTH - 2));
        full_traffic(3);
        set_valid_count('0);
        send_search(tbl_key[0]);
        send_search(rand_key());
        wait_results_idle();
    endtask

    // Result side: random stalls before each word, sometimes none.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        shts_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, found=%0b offset=%h index=%0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[43:32]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, m_tuser);
                    fail_count++;
                end
                if (m_tdata[31:0] !== want.match_offset) begin
                    $display("%0t: match_offset expected %h actual %h",
                             $time, want.match_offset, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[43:32] !== want.match_index) begin
                    $display("%0t: match_index expected %0d actual %0d",
                             $time, want.match_index, m_tdata[43:32]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = KIND_LOAD;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        valid_count_q = '0;
        fail_count    = 0;
        no_gaps       = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_key[i] = '0;
            tbl_off[i] = '0;
            written[i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_table();
        test_small_sorted();
        test_single_entry();
        test_unsorted_table();
        test_random_tables();
        test_full_table();

        wait_results_idle();
        if (fail_count == 0) begin
            $display("tb_sorted_hash_table_search OK");
        end else begin
            $display("tb_sorted_hash_table_search NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/shts_pkg.sv
hdl/shts_table.sv
hdl/shts_search.sv
hdl/sorted_hash_table_search.sv
tb/tb_sorted_hash_table_search.sv
